// File: hw/rtl/jsr_pkg.sv
// Shared types and constants for the job slot registry.
package jsr_pkg;

    localparam logic [6:0]  ProgressFull = 7'd100;

    typedef enum logic [1:0] {
        OP_CREATE   = 2'd0,
        OP_GET      = 2'd1,
        OP_UPDATE   = 2'd2,
        OP_COMPLETE = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EXISTING = 3'd1,
        ST_CONFLICT = 3'd2,
        ST_FULL     = 3'd3,
        ST_INVALID  = 3'd4,
        ST_REJECTED = 3'd5
    } t_status;

    localparam logic [2:0] JS_QUEUED    = 3'd0;
    localparam logic [2:0] JS_RUNNING   = 3'd1;
    localparam logic [2:0] JS_SUCCESS   = 3'd2;
    localparam logic [2:0] JS_TIMEOUT   = 3'd5;

    localparam logic [7:0] PH_QUEUED    = 8'd1;
    localparam logic [7:0] PH_COMPLETED = 8'd2;

    localparam logic CFG_RETENTION = 1'b0;
    localparam logic CFG_NONCE     = 1'b1;

    // One slot record as stored in the table.
    typedef struct packed {
        logic [31:0] request;
        logic [31:0] fingerprint;
        logic [31:0] sequence_no;
        logic [3:0]  job_type;
        logic [2:0]  state;
        logic [7:0]  phase;
        logic [7:0]  error;
        logic [6:0]  progress;
        logic [31:0] media;
        logic [47:0] created;
        logic [47:0] started;
        logic [47:0] finished;
    } t_slot;

    function automatic logic is_terminal(input logic [2:0] s);
        return (s >= JS_SUCCESS) && (s <= JS_TIMEOUT);
    endfunction

    function automatic logic transition_ok(input logic [2:0] prev, input logic [2:0] nxt);
        logic ok;
        ok = 1'b0;
        if (prev == JS_QUEUED) begin
            ok = (nxt <= JS_TIMEOUT) && (nxt != JS_SUCCESS);
        end else if (prev == JS_RUNNING) begin
            ok = (nxt >= JS_RUNNING) && (nxt <= JS_TIMEOUT);
        end
        return ok;
    endfunction

endpackage

// File: hw/rtl/jsr_scan.sv
// Shared per-slot compare unit: examines one slot per cycle for the sequencer.
module jsr_scan
    import jsr_pkg::*;
(
    input  t_slot        i_slot,
    input  logic         i_used,
    input  logic [31:0]  i_key,
    input  logic [31:0]  i_retention,
    input  logic [47:0]  i_now,
    input  logic         i_have_any,
    input  logic [47:0]  i_best_any,
    input  logic         i_have_ret,
    input  logic [47:0]  i_best_ret,
    output logic         o_req_hit,
    output logic         o_seq_hit,
    output logic         o_take_any,
    output logic         o_take_ret
);
    logic        cand;
    logic [47:0] age;

    // Compare key, then reclaim candidacy and age.
    always_comb begin
        o_req_hit  = i_used && (i_slot.request == i_key);
        o_seq_hit  = i_used && (i_slot.sequence_no == i_key);
        cand       = i_used && is_terminal(i_slot.state) && (i_slot.finished != '0);
        age        = i_now - i_slot.finished;
        o_take_any = cand && (!i_have_any || (i_slot.finished < i_best_any));
        o_take_ret = cand && (age >= {16'd0, i_retention}) &&
                     (!i_have_ret || (i_slot.finished < i_best_ret));
    end
endmodule

// File: hw/rtl/job_slot_registry.sv
// Top level of the job slot registry: slot table, sequencer and ports.
//
// Usage: one command enters on the input channel (i_in_valid / o_in_stall);
// one result leaves on the output channel (o_out_valid / i_out_stall).
// A transfer happens at a clock edge with valid high and stall low.
// Each command walks the table one slot per cycle through a single compare
// unit: a lookup pass over all SLOT_COUNT slots, and for a create that misses
// and finds no free slot a second reclaim pass over them, plus the accept,
// write-back and present states. A command refused at accept (empty key,
// zero handle, empty phase, foreign nonce) skips the scan and goes straight
// from accept to present.
// o_in_stall stays high from accept until the result is taken.
// If the receiver stalls, the result holds in the output register and the
// block waits. Configuration writes (i_cfg_valid/o_cfg_ready, index 0
// retention_ms, 1 boot_nonce) are always taken and should be made while idle.
// Synchronous active-low reset clears the occupied marks, sequence counter,
// state and configuration registers; no clearing pass is needed.
module job_slot_registry
    import jsr_pkg::*;
#(
    parameter int SLOT_COUNT = 8
)(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    input  logic         i_in_valid,
    output logic         o_in_stall,
    input  logic [1:0]   i_operation,
    input  logic [31:0]  i_request_key,
    input  logic [31:0]  i_fingerprint_key,
    input  logic [3:0]   i_job_type,
    input  logic [63:0]  i_job_handle,
    input  logic [2:0]   i_new_state,
    input  logic [7:0]   i_phase_in,
    input  logic [7:0]   i_progress_in,
    input  logic [7:0]   i_error_in,
    input  logic [31:0]  i_media_in,
    input  logic [47:0]  i_now_ms,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output logic [2:0]   o_status,
    output logic [63:0]  o_job_handle_out,
    output logic [31:0]  o_request_key_out,
    output logic [3:0]   o_job_type_out,
    output logic [2:0]   o_state_out,
    output logic [7:0]   o_phase_out,
    output logic [6:0]   o_progress_out,
    output logic [7:0]   o_error_out,
    output logic [31:0]  o_media_out,
    output logic [47:0]  o_created_out,
    output logic [47:0]  o_started_out,
    output logic [47:0]  o_finished_out
);
    localparam int IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IdxW:0] LastIdx = (IdxW + 1)'(SLOT_COUNT - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_LOOK, S_RECLAIM, S_APPLY, S_OUT
    } t_state;

    t_state          r_state;
    t_slot           r_tab [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_used;
    logic [31:0]     r_seq_ctr, r_retention, r_nonce;
    logic [IdxW:0]   r_idx;
    logic            r_hit, r_have_any, r_have_ret, r_free;
    logic [IdxW-1:0] r_hit_idx, r_any_idx, r_ret_idx, r_free_idx;
    logic [47:0]     r_best_any, r_best_ret;

    t_op             r_op;
    logic [31:0]     r_req, r_fp, r_media;
    logic [3:0]      r_type;
    logic [63:0]     r_handle;
    logic [2:0]      r_nst;
    logic [7:0]      r_phase, r_prog, r_err;
    logic [47:0]     r_now;

    logic [2:0]      r_status;
    t_slot           r_res;
    logic            r_res_zero;

    logic [IdxW-1:0] cur;
    logic            req_hit, seq_hit, take_any, take_ret;
    logic [31:0]     key;
    t_slot           sel, upd;
    logic [IdxW-1:0] tgt;

    assign cur = r_idx[IdxW-1:0];
    assign key = (r_op == OP_CREATE) ? r_req : r_handle[31:0];
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_OUT);

    jsr_scan u_scan (
        .i_slot      (r_tab[cur]),
        .i_used      (r_used[cur]),
        .i_key       (key),
        .i_retention (r_retention),
        .i_now       (r_now),
        .i_have_any  (r_have_any),
        .i_best_any  (r_best_any),
        .i_have_ret  (r_have_ret),
        .i_best_ret  (r_best_ret),
        .o_req_hit   (req_hit),
        .o_seq_hit   (seq_hit),
        .o_take_any  (take_any),
        .o_take_ret  (take_ret)
    );

    // Pick the target slot and build its updated record.
    always_comb begin
        if (r_op == OP_CREATE && !r_hit) begin
            tgt = r_free ? r_free_idx : (r_have_ret ? r_ret_idx : r_any_idx);
        end else begin
            tgt = r_hit_idx;
        end
        sel = r_tab[tgt];
        upd = sel;
        unique case (r_op)
            OP_CREATE: begin
                upd.request     = r_req;
                upd.fingerprint = r_fp;
                upd.sequence_no = r_seq_ctr;
                upd.job_type    = r_type;
                upd.state       = JS_QUEUED;
                upd.phase       = PH_QUEUED;
                upd.error       = '0;
                upd.progress    = '0;
                upd.media       = '0;
                upd.created     = r_now;
                upd.started     = '0;
                upd.finished    = '0;
            end
            OP_UPDATE: begin
                if (r_nst == JS_RUNNING && sel.started == '0) upd.started = r_now;
                upd.state    = r_nst;
                upd.phase    = r_phase;
                upd.error    = r_err;
                upd.progress = (r_prog > 8'd100) ? ProgressFull : r_prog[6:0];
                if (is_terminal(r_nst)) upd.finished = r_now;
                if (r_nst == JS_SUCCESS) upd.progress = ProgressFull;
            end
            OP_COMPLETE: begin
                if (sel.started == '0) upd.started = r_now;
                upd.state    = JS_SUCCESS;
                upd.phase    = PH_COMPLETED;
                upd.error    = '0;
                upd.progress = ProgressFull;
                upd.media    = r_media;
                upd.finished = r_now;
            end
            default: ;
        endcase
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retention <= 32'd60000;
            r_nonce     <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_RETENTION) r_retention <= i_cfg_data;
            else                              r_nonce     <= i_cfg_data;
        end
    end

    // Sequencer: accept, scan, reclaim, write back, present.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_used    <= '0;
            r_seq_ctr <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_in_valid) begin
                    r_op <= t_op'(i_operation); r_req <= i_request_key;
                    r_fp <= i_fingerprint_key; r_type <= i_job_type;
                    r_handle <= i_job_handle; r_nst <= i_new_state;
                    r_phase <= i_phase_in; r_prog <= i_progress_in;
                    r_err <= i_error_in; r_media <= i_media_in; r_now <= i_now_ms;
                    r_idx <= '0; r_hit <= 1'b0; r_free <= 1'b0;
                    r_have_any <= 1'b0; r_have_ret <= 1'b0;
                    r_res_zero <= 1'b1;
                    if (t_op'(i_operation) == OP_CREATE) begin
                        if (i_request_key == '0 || i_fingerprint_key == '0) begin
                            r_status <= ST_INVALID; r_state <= S_OUT;
                        end else r_state <= S_LOOK;
                    end else if (i_job_handle == '0 ||
                                 (t_op'(i_operation) == OP_UPDATE && i_phase_in == '0)) begin
                        r_status <= ST_INVALID; r_state <= S_OUT;
                    end else if (i_job_handle[63:32] != r_nonce) begin
                        r_status <= ST_REJECTED; r_state <= S_OUT;
                    end else r_state <= S_LOOK;
                end
                S_LOOK: begin
                    if (!r_hit && ((r_op == OP_CREATE) ? req_hit : seq_hit)) begin
                        r_hit <= 1'b1; r_hit_idx <= cur;
                    end
                    if (!r_free && !r_used[cur]) begin
                        r_free <= 1'b1; r_free_idx <= cur;
                    end
                    if (r_idx == LastIdx) begin
                        r_idx <= '0;
                        r_state <= (r_op == OP_CREATE && !(r_hit || req_hit) &&
                                    !(r_free || !r_used[cur])) ? S_RECLAIM : S_APPLY;
                    end else r_idx <= r_idx + 1'b1;
                end
                S_RECLAIM: begin
                    if (take_any) begin
                        r_have_any <= 1'b1; r_any_idx <= cur;
                        r_best_any <= r_tab[cur].finished;
                    end
                    if (take_ret) begin
                        r_have_ret <= 1'b1; r_ret_idx <= cur;
                        r_best_ret <= r_tab[cur].finished;
                    end
                    if (r_idx == LastIdx) r_state <= S_APPLY;
                    else r_idx <= r_idx + 1'b1;
                end
                S_APPLY: begin
                    r_state <= S_OUT;
                    r_res   <= sel;
                    if (r_op == OP_CREATE) begin
                        if (r_hit) begin
                            r_status <= (sel.fingerprint == r_fp) ? ST_EXISTING : ST_CONFLICT;
                            r_res_zero <= 1'b0;
                        end else if (!r_free && !r_have_any) begin
                            r_status <= ST_FULL;
                        end else begin
                            r_status <= ST_OK; r_res_zero <= 1'b0;
                            r_tab[tgt] <= upd; r_res <= upd;
                            r_used[tgt] <= 1'b1;
                            r_seq_ctr <= r_seq_ctr + 1'b1;
                        end
                    end else if (!r_hit) begin
                        r_status <= ST_REJECTED;
                    end else if (r_op == OP_GET) begin
                        r_status <= ST_OK; r_res_zero <= 1'b0;
                    end else if (!transition_ok(sel.state,
                                 (r_op == OP_UPDATE) ? r_nst : JS_SUCCESS)) begin
                        r_status <= ST_REJECTED;
                    end else begin
                        r_status <= ST_OK; r_res_zero <= 1'b0;
                        r_tab[tgt] <= upd; r_res <= upd;
                    end
                end
                S_OUT: if (!i_out_stall) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Result fields; zero for plain status results.
    assign o_status          = r_status;
    assign o_job_handle_out  = r_res_zero ? '0 : {r_nonce, r_res.sequence_no};
    assign o_request_key_out = r_res_zero ? '0 : r_res.request;
    assign o_job_type_out    = r_res_zero ? '0 : r_res.job_type;
    assign o_state_out       = r_res_zero ? '0 : r_res.state;
    assign o_phase_out       = r_res_zero ? '0 : r_res.phase;
    assign o_progress_out    = r_res_zero ? '0 : r_res.progress;
    assign o_error_out       = r_res_zero ? '0 : r_res.error;
    assign o_media_out       = r_res_zero ? '0 : r_res.media;
    assign o_created_out     = r_res_zero ? '0 : r_res.created;
    assign o_started_out     = r_res_zero ? '0 : r_res.started;
    assign o_finished_out    = r_res_zero ? '0 : r_res.finished;

`ifndef SYNTHESIS
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall) else $error("stall low while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid) else $error("result dropped");
    a_seq_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq_ctr != $past(r_seq_ctr)) |-> ($past(r_state) == S_APPLY))
        else $error("sequence moved outside write back");
`endif
endmodule
